/* src/htu_pkg.sv */
// Shared types, widths and operation codes for the homogeneous transform unit.
`timescale 1ns / 1ps

package htu_pkg;

    // Fixed-point format of every matrix element and operand.
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 3;
    // The reciprocal dividend is 2^(2*FRAC_BITS) plus half the divisor.
    localparam int DIV_W     = (2 * FRAC_BITS + 1 > DATA_W) ? 2 * FRAC_BITS + 1 : DATA_W;
    localparam int DCNT_W    = 6;

    typedef logic signed [DATA_W-1:0] t_word;

    localparam t_word FIX_ONE  = t_word'(64'sd1 <<< FRAC_BITS);
    localparam t_word WORD_MAX = 32'sh7fff_ffff;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        OP_IDENT     = 4'd0,
        OP_WRITE     = 4'd1,
        OP_READ      = 4'd2,
        OP_TRANSLATE = 4'd3,
        OP_SCALE     = 4'd4,
        OP_ROT_X     = 4'd5,
        OP_ROT_Y     = 4'd6,
        OP_ROT_Z     = 4'd7,
        OP_AXES      = 4'd8,
        OP_SHEAR2D   = 4'd9,
        OP_SHEARZ    = 4'd10,
        OP_PERSP     = 4'd11,
        OP_TRANSPOSE = 4'd12,
        OP_TRANSFORM = 4'd13,
        OP_CLEAR     = 4'd14,
        OP_NOP       = 4'd15
    } t_op;

    // Control that travels with each product through the multiply-accumulate unit.
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [3:0] dot;
    } t_mac_ctl;

    // Negation that saturates the most negative value.
    function automatic t_word sat_neg(input t_word v);
        t_word r;
        if (v == WORD_MIN) begin
            r = WORD_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

endpackage

/* src/htu_mac.sv */
// Shared multiply-accumulate unit with rounding and saturation of each dot product.
`timescale 1ns / 1ps

module htu_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htu_pkg::t_mac_ctl i_ctl,
    input  htu_pkg::t_word    i_a,
    input  htu_pkg::t_word    i_b,
    output htu_pkg::t_mac_ctl o_ctl,
    output htu_pkg::t_word    o_sum
);
    import htu_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(WORD_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_ctl1;
    logic signed [ACC_W-1:0]  r_acc;
    t_mac_ctl                 r_ctl2;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_shift;

    // Product stage, then accumulate stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        if (r_ctl1.valid) begin
            r_acc <= (r_ctl1.first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
        end
    end

    // Round to nearest with ties upward, then saturate to a word.
    always_comb begin
        w_rnd   = r_acc + HALF;
        w_shift = w_rnd >>> FRAC_BITS;
        if (w_shift > ACC_MAX) begin
            o_sum = WORD_MAX;
        end else if (w_shift < ACC_MIN) begin
            o_sum = WORD_MIN;
        end else begin
            o_sum = w_shift[DATA_W-1:0];
        end
    end

    // A sum is complete when the last product of its dot has been added.
    always_comb begin
        o_ctl       = r_ctl2;
        o_ctl.valid = r_ctl2.valid && r_ctl2.last;
    end

endmodule

/* src/htu_div.sv */
// Bit-serial restoring divider that forms the rounded, saturated reciprocal of d.
`timescale 1ns / 1ps

module htu_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  htu_pkg::t_word i_d,
    output logic           o_done,
    output htu_pkg::t_word o_q
);
    import htu_pkg::*;

    logic [DATA_W-1:0] r_ad;
    logic [DIV_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_q;
    logic [DATA_W-1:0] r_rem;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DATA_W:0]   w_abs;
    logic [DATA_W:0]   w_sh;
    logic [DATA_W:0]   w_diff;
    logic              w_ge;

    assign w_abs  = i_d[DATA_W-1] ? -{i_d[DATA_W-1], i_d} : {1'b0, i_d};
    assign w_sh   = {r_rem, r_num[DIV_W-1]};
    assign w_diff = w_sh - {1'b0, r_ad};
    assign w_ge   = (w_sh >= {1'b0, r_ad});

    // One quotient bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_W);
                r_ad   <= w_abs[DATA_W-1:0];
                r_num  <= (DIV_W'(1) << (2 * FRAC_BITS)) + DIV_W'(w_abs[DATA_W-1:1]);
                r_rem  <= '0;
                r_q    <= '0;
                r_neg  <= i_d[DATA_W-1];
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_sh[DATA_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], w_ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Apply the sign of d and saturate.
    always_comb begin
        if (!r_neg) begin
            o_q = (r_q > DIV_W'(33'h0_7fff_ffff)) ? WORD_MAX : r_q[DATA_W-1:0];
        end else begin
            o_q = (r_q > DIV_W'(33'h0_8000_0000)) ? WORD_MIN : -r_q[DATA_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

/* src/homogeneous_transform_unit_top.sv */
// Top level of the homogeneous 4x4 transform unit: matrix store and sequencer.
`timescale 1ns / 1ps

// The unit holds one 4x4 Q16.16 matrix and takes one operation per input beat.
// Input channel: i_valid with o_stall; a beat is taken when i_valid is high and
// o_stall is low. Output channel: o_valid with i_stall; only read and transform
// beats produce a result beat, which is held until i_stall is low.
// Identity, clear, write, transpose and an unknown code complete on acceptance.
// Read moves the element to the result register, then to the output register.
// Transform runs 16 products through the shared multiplier-accumulator and
// then delivers its four results through the output register.
// Translate, scale, rotate, axes and shear premultiply the matrix with 64
// products on that same unit. Perspective first runs the serial reciprocal
// divider (one quotient bit per cycle, 33 quotient bits at Q16.16) and then
// premultiplies; zero d leaves the matrix unchanged and completes on acceptance.
// The single multiplier-accumulator sets the rate; o_stall is high while an
// operation is in progress, and one operation is worked on at a time.
// A stalled receiver holds a result in the output register; a following
// result waits in the sequencer until that beat is taken.
// Reset (i_rst_n low, synchronous) loads the identity matrix and clears both
// channels.

module homogeneous_transform_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_operation,
    input  logic [3:0]  i_element_index,
    input  logic signed [31:0] i_operand_0,
    input  logic signed [31:0] i_operand_1,
    input  logic signed [31:0] i_operand_2,
    input  logic signed [31:0] i_operand_3,
    input  logic signed [31:0] i_operand_4,
    input  logic signed [31:0] i_operand_5,
    input  logic signed [31:0] i_operand_6,
    input  logic signed [31:0] i_operand_7,
    input  logic signed [31:0] i_operand_8,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_result_0,
    output logic signed [31:0] o_result_1,
    output logic signed [31:0] o_result_2,
    output logic signed [31:0] o_result_3
);
    import htu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RUN,
        S_POST
    } t_state;

    t_state            r_state;
    t_op               r_op;
    t_word             r_mat [16];
    t_word             r_opnd [9];
    t_word             r_res [4];
    t_word             r_col [3];
    t_word             r_out [4];
    t_word             r_recip;
    logic              r_out_valid;
    logic              r_iss;
    logic              r_div_start;
    logic [5:0]        r_cnt;
    logic [3:0]        w_raddr;
    logic [3:0]        w_eidx;
    t_word             w_rd;
    t_word             w_e;
    t_word             w_nsin;
    t_word             w_mac_a;
    t_word             w_mac_b;
    t_word             w_sum;
    t_word             w_div_q;
    logic              w_div_done;
    logic              w_is_xform;
    logic              w_iss_last;
    t_mac_ctl          w_ctl;
    t_mac_ctl          w_mac_ctl;
    t_op               w_in_op;

    assign w_in_op    = t_op'(i_operation);
    assign w_is_xform = (r_op == OP_TRANSFORM);
    assign w_iss_last = w_is_xform ? (r_cnt == 6'd15) : (r_cnt == 6'd63);
    assign w_eidx     = r_cnt[3:0];
    assign w_nsin     = sat_neg(r_opnd[1]);

    // Single matrix read port: element index when idle, else the product walk.
    always_comb begin
        if (r_state == S_IDLE) begin
            w_raddr = i_element_index;
        end else if (w_is_xform) begin
            w_raddr = r_cnt[3:0];
        end else begin
            w_raddr = {r_cnt[1:0], r_cnt[5:4]};
        end
    end
    assign w_rd = r_mat[w_raddr];

    // Elementary matrix entry for the current product.
    always_comb begin
        w_e = (w_eidx[3:2] == w_eidx[1:0]) ? FIX_ONE : '0;
        case (r_op)
            OP_TRANSLATE: begin
                if (w_eidx == 4'd3) w_e = r_opnd[0];
                if (w_eidx == 4'd7) w_e = r_opnd[1];
                if (w_eidx == 4'd11) w_e = r_opnd[2];
            end
            OP_SCALE: begin
                if (w_eidx == 4'd0) w_e = r_opnd[0];
                if (w_eidx == 4'd5) w_e = r_opnd[1];
                if (w_eidx == 4'd10) w_e = r_opnd[2];
            end
            OP_ROT_X: begin
                if (w_eidx == 4'd5 || w_eidx == 4'd10) w_e = r_opnd[0];
                if (w_eidx == 4'd6) w_e = w_nsin;
                if (w_eidx == 4'd9) w_e = r_opnd[1];
            end
            OP_ROT_Y: begin
                if (w_eidx == 4'd0 || w_eidx == 4'd10) w_e = r_opnd[0];
                if (w_eidx == 4'd2) w_e = r_opnd[1];
                if (w_eidx == 4'd8) w_e = w_nsin;
            end
            OP_ROT_Z: begin
                if (w_eidx == 4'd0 || w_eidx == 4'd5) w_e = r_opnd[0];
                if (w_eidx == 4'd1) w_e = w_nsin;
                if (w_eidx == 4'd4) w_e = r_opnd[1];
            end
            OP_AXES: begin
                case (w_eidx)
                    4'd0:    w_e = r_opnd[0];
                    4'd1:    w_e = r_opnd[1];
                    4'd2:    w_e = r_opnd[2];
                    4'd4:    w_e = r_opnd[3];
                    4'd5:    w_e = r_opnd[4];
                    4'd6:    w_e = r_opnd[5];
                    4'd8:    w_e = r_opnd[6];
                    4'd9:    w_e = r_opnd[7];
                    4'd10:   w_e = r_opnd[8];
                    default: ;
                endcase
            end
            OP_SHEAR2D: begin
                if (w_eidx == 4'd1) w_e = r_opnd[0];
                if (w_eidx == 4'd4) w_e = r_opnd[1];
            end
            OP_SHEARZ: begin
                if (w_eidx == 4'd2) w_e = r_opnd[0];
                if (w_eidx == 4'd6) w_e = r_opnd[1];
            end
            OP_PERSP: begin
                if (w_eidx == 4'd14) w_e = r_recip;
                if (w_eidx == 4'd15) w_e = '0;
            end
            default: ;
        endcase
    end

    // Operands and control for the shared multiply-accumulate unit.
    always_comb begin
        w_mac_a     = w_is_xform ? w_rd : w_e;
        w_mac_b     = w_is_xform ? r_opnd[r_cnt[1:0]] : w_rd;
        w_ctl.valid = r_iss;
        w_ctl.first = (r_cnt[1:0] == 2'd0);
        w_ctl.last  = (r_cnt[1:0] == 2'd3);
        w_ctl.dot   = r_cnt[5:2];
    end

    htu_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_ctl   (w_mac_ctl),
        .o_sum   (w_sum)
    );

    htu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_d     (r_opnd[0]),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    // Sequencer, matrix store and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iss       <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_op        <= OP_NOP;
            r_cnt       <= '0;
            for (int k = 0; k < 16; k++) begin
                r_mat[k] <= (k % 5 == 0) ? FIX_ONE : '0;
            end
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op      <= w_in_op;
                        r_cnt     <= '0;
                        r_opnd[0] <= i_operand_0;
                        r_opnd[1] <= i_operand_1;
                        r_opnd[2] <= i_operand_2;
                        r_opnd[3] <= i_operand_3;
                        r_opnd[4] <= i_operand_4;
                        r_opnd[5] <= i_operand_5;
                        r_opnd[6] <= i_operand_6;
                        r_opnd[7] <= i_operand_7;
                        r_opnd[8] <= i_operand_8;
                        case (w_in_op)
                            OP_IDENT: begin
                                for (int k = 0; k < 16; k++) begin
                                    r_mat[k] <= (k % 5 == 0) ? FIX_ONE : '0;
                                end
                            end
                            OP_CLEAR: begin
                                for (int k = 0; k < 16; k++) begin
                                    r_mat[k] <= '0;
                                end
                            end
                            OP_WRITE: begin
                                r_mat[i_element_index] <= i_operand_0;
                            end
                            OP_READ: begin
                                r_res[0] <= w_rd;
                                r_res[1] <= '0;
                                r_res[2] <= '0;
                                r_res[3] <= '0;
                                r_state  <= S_POST;
                            end
                            OP_TRANSPOSE: begin
                                for (int rw = 0; rw < 4; rw++) begin
                                    for (int cl = 0; cl < 4; cl++) begin
                                        r_mat[cl * 4 + rw] <= r_mat[rw * 4 + cl];
                                    end
                                end
                            end
                            OP_PERSP: begin
                                if (i_operand_0 != '0) begin
                                    r_div_start <= 1'b1;
                                    r_state     <= S_DIV;
                                end
                            end
                            OP_TRANSLATE, OP_SCALE, OP_ROT_X, OP_ROT_Y, OP_ROT_Z,
                            OP_AXES, OP_SHEAR2D, OP_SHEARZ, OP_TRANSFORM: begin
                                r_iss   <= 1'b1;
                                r_state <= S_RUN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_recip <= w_div_q;
                        r_iss   <= 1'b1;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_iss) begin
                        r_cnt <= r_cnt + 6'd1;
                        if (w_iss_last) begin
                            r_iss <= 1'b0;
                        end
                    end
                    if (w_mac_ctl.valid) begin
                        if (w_is_xform) begin
                            r_res[w_mac_ctl.dot[1:0]] <= w_sum;
                            if (w_mac_ctl.dot == 4'd3) begin
                                r_state <= S_POST;
                            end
                        end else if (w_mac_ctl.dot[1:0] != 2'd3) begin
                            r_col[w_mac_ctl.dot[1:0]] <= w_sum;
                        end else begin
                            // Column finished: write all four of its elements back together.
                            for (int rw = 0; rw < 3; rw++) begin
                                r_mat[{2'(rw), w_mac_ctl.dot[3:2]}] <= r_col[rw];
                            end
                            r_mat[{2'd3, w_mac_ctl.dot[3:2]}] <= w_sum;
                            if (w_mac_ctl.dot == 4'd15) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_POST: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_result_0 = r_out[0];
    assign o_result_1 = r_out[1];
    assign o_result_2 = r_out[2];
    assign o_result_3 = r_out[3];

    // A finished dot product only arrives while products are being run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_ctl.valid |-> (r_state == S_RUN))
        else $error("dot product completed outside the run state");

    // The reciprocal is only reported while the sequencer waits for it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // Products are issued only in the run state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss |-> (r_state == S_RUN))
        else $error("product issued outside the run state");

    // A stalled result beat is not overwritten by a later result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_0) && $stable(o_result_3)))
        else $error("stalled result beat was lost or changed");

endmodule
